[rtl/core/stopwatch_seven_segment_scan_macros.svh]
// Assertion macros for the stopwatch display scan.
`ifndef STOPWATCH_SEVEN_SEGMENT_SCAN_MACROS_SVH
`define STOPWATCH_SEVEN_SEGMENT_SCAN_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SW7_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stopwatch scan: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SW7_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stopwatch scan: next-cycle check failed");

`endif

[rtl/core/sw7seg_pkg.sv]
// Types, constants and the segment decoder for the stopwatch display scan.
package sw7seg_pkg;

    localparam int DIGIT_SLOTS = 4;
    localparam int SLOT_W = $clog2(DIGIT_SLOTS);

    localparam logic [SLOT_W-1:0] POINT_INDEX = SLOT_W'(DIGIT_SLOTS - 2);
    localparam logic [SLOT_W-1:0] LAST_INDEX = SLOT_W'(DIGIT_SLOTS - 1);

    localparam int COUNT_W = 14;
    localparam int PHASE_W = 10;
    localparam int QUIET_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_TOP = 14'd9999;
    localparam logic [QUIET_W-1:0] QUIET_MAX = 16'hFFFF;

    localparam logic [QUIET_W-1:0] DEBOUNCE_RESET = 16'd200;
    localparam logic [PHASE_W-1:0] TICKS_RESET = 10'd10;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS = 1'd1;

    typedef logic [DIGIT_SLOTS-1:0][3:0] bcd_t;

    typedef struct packed {
        logic start_stop_press;
        logic reset_press;
    } tick_t;

    typedef struct packed {
        logic [3:0]         digit_select;
        logic [6:0]         segments;
        logic               decimal_point;
        logic [COUNT_W-1:0] shown_count;
        logic               last_digit;
    } digit_t;

    function automatic logic [6:0] seg_of(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0: s = 7'h3F;
            4'd1: s = 7'h06;
            4'd2: s = 7'h5B;
            4'd3: s = 7'h4F;
            4'd4: s = 7'h66;
            4'd5: s = 7'h6D;
            4'd6: s = 7'h7D;
            4'd7: s = 7'h07;
            4'd8: s = 7'h7F;
            4'd9: s = 7'h67;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

[rtl/core/stopwatch_seven_segment_scan.sv]
// Stopwatch with debounced buttons and a four-digit multiplexed display scan.
//
// tick channel: one transfer per millisecond tick, carrying the start/stop
// and reset press flags. The stopwatch state is updated in the cycle the
// tick is taken; the count is held in binary and in BCD side by side.
// digit channel: four transfers per tick, least significant slot first,
// each with the cathode select, segments, decimal point and shown count;
// last_digit marks the fourth.
// cfg channel: cfg_ready is always high; index 0 is debounce_ms, index 1
// is ticks_per_count (a value of 0 counts as 1).
// With the digit stage idle, a taken tick is held in the holding stage
// (pend_valid_reg) and is then loaded into the digit scan stage, from which
// its digits transfer. A tick's four digits all leave through the single
// digit output port; a tick is taken into a one-entry holding stage while
// the previous tick's digits are still being sent.
// Reset: debounce 200, 10 ticks per count, count 0, running, quiet timers 0,
// no digits pending.
// When digit_ready is low the current digit holds and at most one further
// tick is taken; tick_ready then stays low until the digit stage drains.
module stopwatch_seven_segment_scan (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   tick_valid,
    output logic                                   tick_ready,
    input  sw7seg_pkg::tick_t                      tick,
    output logic                                   digit_valid,
    input  logic                                   digit_ready,
    output sw7seg_pkg::digit_t                     digit,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sw7seg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sw7seg_pkg::CFG_DATA_W-1:0]      cfg_data
);

`include "stopwatch_seven_segment_scan_macros.svh"

    logic [sw7seg_pkg::QUIET_W-1:0]   debounce_reg;
    logic [sw7seg_pkg::PHASE_W-1:0]   ticks_reg;
    logic [sw7seg_pkg::PHASE_W-1:0]   phase_reg, phase_next;
    logic [sw7seg_pkg::COUNT_W-1:0]   count_reg, count_next;
    sw7seg_pkg::bcd_t                 bcd_reg, bcd_next;
    logic                             running_reg, running_next;
    logic [sw7seg_pkg::QUIET_W-1:0]   ss_quiet_reg, ss_quiet_next;
    logic [sw7seg_pkg::QUIET_W-1:0]   rs_quiet_reg, rs_quiet_next;
    logic                             pend_valid_reg;

    logic                             out_valid_reg;
    logic [sw7seg_pkg::SLOT_W-1:0]    slot_reg;
    logic [sw7seg_pkg::COUNT_W-1:0]   out_count_reg;
    sw7seg_pkg::bcd_t                 out_bcd_reg;

    logic                             tick_xfer;
    logic                             digit_xfer;
    logic                             out_free;
    logic                             out_load;
    logic [sw7seg_pkg::PHASE_W-1:0]   period;
    logic [sw7seg_pkg::PHASE_W:0]     phase_inc;
    logic                             wrap;
    logic [sw7seg_pkg::QUIET_W-1:0]   ss_adv, rs_adv;
    logic [sw7seg_pkg::COUNT_W-1:0]   count_inc;
    sw7seg_pkg::bcd_t                 bcd_inc;
    logic                             carry;

    assign tick_ready  = !pend_valid_reg;
    assign tick_xfer   = tick_valid && tick_ready;
    assign digit_valid = out_valid_reg;
    assign digit_xfer  = out_valid_reg && digit_ready;
    assign out_free    = !out_valid_reg || (digit_xfer && slot_reg == sw7seg_pkg::LAST_INDEX);
    assign out_load    = pend_valid_reg && out_free;
    assign cfg_ready   = 1'b1;

    // tick update
    always_comb
    begin
        period    = (ticks_reg == '0) ? sw7seg_pkg::PHASE_W'(1) : ticks_reg;
        phase_inc = {1'b0, phase_reg} + (sw7seg_pkg::PHASE_W+1)'(1);
        wrap      = phase_inc >= {1'b0, period};
        ss_adv    = (ss_quiet_reg == sw7seg_pkg::QUIET_MAX) ? ss_quiet_reg
                                                            : ss_quiet_reg + 1'b1;
        rs_adv    = (rs_quiet_reg == sw7seg_pkg::QUIET_MAX) ? rs_quiet_reg
                                                            : rs_quiet_reg + 1'b1;
        count_inc = (count_reg == sw7seg_pkg::COUNT_TOP) ? '0 : count_reg + 1'b1;

        carry = 1'b1;
        for (int i = 0; i < sw7seg_pkg::DIGIT_SLOTS; i++)
        begin
            if (carry && bcd_reg[i] == 4'd9)
            begin
                bcd_inc[i] = 4'd0;
            end
            else
            begin
                bcd_inc[i] = bcd_reg[i] + {3'd0, carry};
                carry      = 1'b0;
            end
        end

        phase_next    = wrap ? '0 : phase_inc[sw7seg_pkg::PHASE_W-1:0];
        count_next    = count_reg;
        bcd_next      = bcd_reg;
        running_next  = running_reg;
        ss_quiet_next = ss_adv;
        rs_quiet_next = rs_adv;

        if (wrap && running_reg)
        begin
            count_next = count_inc;
            bcd_next   = bcd_inc;
        end
        if (tick.reset_press && rs_adv > debounce_reg)
        begin
            count_next    = '0;
            bcd_next      = '0;
            rs_quiet_next = '0;
        end
        if (tick.start_stop_press && ss_adv > debounce_reg)
        begin
            running_next  = !running_reg;
            ss_quiet_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= sw7seg_pkg::DEBOUNCE_RESET;
            ticks_reg    <= sw7seg_pkg::TICKS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sw7seg_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_data;
                sw7seg_pkg::CFG_TICKS:    ticks_reg <= cfg_data[sw7seg_pkg::PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            count_reg    <= '0;
            bcd_reg      <= '0;
            running_reg  <= 1'b1;
            ss_quiet_reg <= '0;
            rs_quiet_reg <= '0;
        end
        else if (tick_xfer)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            bcd_reg      <= bcd_next;
            running_reg  <= running_next;
            ss_quiet_reg <= ss_quiet_next;
            rs_quiet_reg <= rs_quiet_next;
        end
    end

    // holding stage: the state registers carry its count until it moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (tick_xfer)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    // digit scan stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            slot_reg      <= '0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
            slot_reg      <= '0;
        end
        else if (digit_xfer)
        begin
            if (slot_reg == sw7seg_pkg::LAST_INDEX)
            begin
                out_valid_reg <= 1'b0;
            end
            slot_reg <= slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_count_reg <= count_reg;
            out_bcd_reg   <= bcd_reg;
        end
    end

    always_comb
    begin
        digit.digit_select  = 4'b1000 >> slot_reg;
        digit.segments      = sw7seg_pkg::seg_of(out_bcd_reg[slot_reg]);
        digit.decimal_point = slot_reg == sw7seg_pkg::POINT_INDEX;
        digit.shown_count   = out_count_reg;
        digit.last_digit    = slot_reg == sw7seg_pkg::LAST_INDEX;
    end

    `SW7_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_reg <= sw7seg_pkg::COUNT_TOP)
    `SW7_ASSERT_NEXT(a_pend_moves, clk, rst_n, pend_valid_reg && !out_valid_reg, out_valid_reg && !pend_valid_reg)
    `SW7_ASSERT_NEXT(a_scan_ends, clk, rst_n, digit_xfer && digit.last_digit && !pend_valid_reg, !out_valid_reg)

endmodule

[verif/tb.sv]
// Testbench for the stopwatch display scan: stimulus, prediction and checking.
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT = 2000;
    localparam int PRINT_CAP = 100;
    localparam logic [9:0][6:0] SEG_FONT = {
        7'h67, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic tick_valid = 1'b0;
    logic tick_ready;
    sw7seg_pkg::tick_t tick = '0;
    logic digit_valid;
    logic digit_ready = 1'b0;
    sw7seg_pkg::digit_t digit;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [sw7seg_pkg::CFG_INDEX_W-1:0] cfg_index = sw7seg_pkg::CFG_DEBOUNCE;
    logic [sw7seg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // stopwatch state as the block should hold it
    logic [15:0] debounce_cfg = sw7seg_pkg::DEBOUNCE_RESET;
    logic [9:0] ticks_cfg = sw7seg_pkg::TICKS_RESET;
    logic [9:0] div_phase = '0;
    logic [13:0] centis = '0;
    logic running = 1'b1;
    logic [15:0] ss_quiet = '0;
    logic [15:0] rs_quiet = '0;

    sw7seg_pkg::digit_t pending_digits[$];
    sw7seg_pkg::digit_t want;
    int mismatches = 0;
    int idle_cycles = 0;
    int gap_pct = 0;
    int stall_pct = 0;

    stopwatch_seven_segment_scan u_top (
        .clk(clk),
        .rst_n(rst_n),
        .tick_valid(tick_valid),
        .tick_ready(tick_ready),
        .tick(tick),
        .digit_valid(digit_valid),
        .digit_ready(digit_ready),
        .digit(digit),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        digit_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int exp_val, input int got_val);
        if (exp_val != got_val)
            report_mismatch($sformatf("%s expected %0d, got %0d", name, exp_val, got_val));
    endtask

    // advance the stopwatch by one tick and queue the four digits it shows
    function automatic void advance_stopwatch(input sw7seg_pkg::tick_t t);
        int period;
        int rest;
        sw7seg_pkg::digit_t d;
        period = (ticks_cfg == 0) ? 1 : int'(ticks_cfg);
        if (ss_quiet != 16'hFFFF)
            ss_quiet = ss_quiet + 16'd1;
        if (rs_quiet != 16'hFFFF)
            rs_quiet = rs_quiet + 16'd1;
        if (int'(div_phase) + 1 >= period)
        begin
            div_phase = '0;
            if (running)
                centis = (centis == sw7seg_pkg::COUNT_TOP) ? '0 : centis + 14'd1;
        end
        else
        begin
            div_phase = div_phase + 10'd1;
        end
        if (t.reset_press && rs_quiet > debounce_cfg)
        begin
            centis = '0;
            rs_quiet = '0;
        end
        if (t.start_stop_press && ss_quiet > debounce_cfg)
        begin
            running = !running;
            ss_quiet = '0;
        end
        rest = int'(centis);
        for (int k = 0; k < sw7seg_pkg::DIGIT_SLOTS; k++)
        begin
            d.digit_select = 4'd1 << (sw7seg_pkg::DIGIT_SLOTS - 1 - k);
            d.segments = SEG_FONT[rest % 10];
            d.decimal_point = (k == sw7seg_pkg::DIGIT_SLOTS - 2);
            d.shown_count = centis;
            d.last_digit = (k == sw7seg_pkg::DIGIT_SLOTS - 1);
            pending_digits.push_back(d);
            rest = rest / 10;
        end
    endfunction

    // transfer monitor: config, prediction, checking, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == sw7seg_pkg::CFG_DEBOUNCE)
                    debounce_cfg = cfg_data;
                else
                    ticks_cfg = cfg_data[9:0];
            end
            if (tick_valid && tick_ready)
                advance_stopwatch(tick);
            if (digit_valid && digit_ready)
            begin
                if (pending_digits.size() == 0)
                begin
                    report_mismatch($sformatf("digit with none pending, shown_count %0d",
                                              digit.shown_count));
                end
                else
                begin
                    want = pending_digits.pop_front();
                    check_field("digit_select", want.digit_select, digit.digit_select);
                    check_field("segments", want.segments, digit.segments);
                    check_field("decimal_point", want.decimal_point, digit.decimal_point);
                    check_field("shown_count", want.shown_count, digit.shown_count);
                    check_field("last_digit", want.last_digit, digit.last_digit);
                end
            end
            if ((cfg_valid && cfg_ready) || (tick_valid && tick_ready)
                || (digit_valid && digit_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("FAILED: results differ");
                    $finish;
                end
            end
        end
    end

    task automatic send_tick(input logic ss, input logic rs);
        sw7seg_pkg::tick_t t;
        t.start_stop_press = ss;
        t.reset_press = rs;
        while ($urandom_range(99) < gap_pct)
        begin
            tick_valid <= 1'b0;
            @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick <= t;
        @(posedge clk);
        while (!tick_ready)
            @(posedge clk);
    endtask

    // let the clock advance first so the last accepted tick is already queued
    task automatic wait_drain();
        tick_valid <= 1'b0;
        @(posedge clk);
        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] deb, input logic [9:0] tpc);
        cfg_valid <= 1'b1;
        cfg_index <= sw7seg_pkg::CFG_DEBOUNCE;
        cfg_data <= deb;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= sw7seg_pkg::CFG_TICKS;
        cfg_data <= {6'd0, tpc};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // reset values: presses fall inside the debounce window
    task automatic test_defaults();
        gap_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < 11; i++)
            send_tick(i[0], i[1]);
    endtask

    // zero period acts as one; every press taken, both at once resets then toggles
    task automatic test_presses();
        wait_drain();
        set_config(16'd0, 10'd0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
    endtask

    // lowering the period below the current phase wraps on the next tick
    task automatic test_phase_beyond_period();
        wait_drain();
        set_config(16'd0, 10'd1000);
        repeat (5) send_tick(1'b0, 1'b0);
        wait_drain();
        set_config(16'd0, 10'd3);
        repeat (2) send_tick(1'b0, 1'b0);
    endtask

    task automatic test_random(input int n, input int gap, input int stall);
        logic [15:0] deb;
        logic [9:0] tpc;
        case ($urandom_range(4))
            0: deb = 16'd0;
            1, 2: deb = 16'($urandom_range(1, 6));
            3: deb = 16'($urandom_range(7, 40));
            default: deb = 16'($urandom_range(65535));
        endcase
        case ($urandom_range(3))
            0: tpc = 10'($urandom_range(1));
            1: tpc = 10'd1;
            2: tpc = 10'($urandom_range(2, 12));
            default: tpc = 10'($urandom_range(1023));
        endcase
        wait_drain();
        set_config(deb, tpc);
        gap_pct = gap;
        stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(39) == 0)
                wait_drain();
            send_tick($urandom_range(3) == 0, $urandom_range(3) == 0);
        end
    endtask

    // largest debounce blocks every press of both buttons
    task automatic test_largest_debounce();
        wait_drain();
        gap_pct = 0;
        stall_pct = 0;
        set_config(16'hFFFF, 10'd1);
        repeat (6) send_tick(1'b1, 1'b1);
        repeat (2) send_tick(1'b0, 1'b0);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_defaults();
        test_presses();
        test_phase_beyond_period();
        test_random(75, 0, 0);
        test_random(75, 72, 0);
        test_random(75, 0, 72);
        test_random(75, 23, 23);
        test_largest_debounce();
        wait_drain();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
